/* rtl/smpq_pkg.sv */
// ---------------------------------------------------------------------------
// smpq_pkg: shared types and constants of the sorted minimum priority queue
// Entry and command types for the cell chain, item codes and field widths.
// ---------------------------------------------------------------------------
package smpq_pkg;

	localparam int KEY_W       = 32;
	localparam int LABEL_W     = 16;
	localparam int COUNT_OUT_W = 7;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_DEF   = 64;

	// Item kinds on the input side.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [LABEL_W-1:0] label;
	} entry_t;

	// Broadcast to every cell in the cycle an item is accepted.
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t ent;
	} cmd_t;

endpackage

/* rtl/smpq_cell.sv */
// ---------------------------------------------------------------------------
// smpq_cell: one slot of the sorted queue
// Holds one entry and moves toward a neighbor or takes the new entry.
// ---------------------------------------------------------------------------
module smpq_cell #(
	parameter int INDEX   = 0,
	parameter int COUNT_W = 7
) (
	input  logic                 clk,
	input  smpq_pkg::cmd_t       cmd,
	input  logic [COUNT_W-1:0]   count,
	input  logic                 left_ge,
	input  smpq_pkg::entry_t     left_ent,
	input  smpq_pkg::entry_t     right_ent,
	output logic                 ge,
	output smpq_pkg::entry_t     ent
);

	smpq_pkg::entry_t ent_q;
	logic             occupied;

	// A slot is occupied when it lies below the fill count.
	assign occupied = count > COUNT_W'(INDEX);
	// The new entry goes at or before this slot.
	assign ge  = !occupied || (ent_q.key >= cmd.ent.key);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_ge) begin
				ent_q <= left_ent;
			end else if (ge) begin
				ent_q <= cmd.ent;
			end
		end else if (cmd.rem) begin
			ent_q <= right_ent;
		end
	end

endmodule

/* rtl/sorted_min_priority_queue.sv */
// ---------------------------------------------------------------------------
// sorted_min_priority_queue: bounded queue kept sorted, smallest key first
// A chain of cells holds the entries in order; every item returns the head.
// ---------------------------------------------------------------------------
//
// Channel  Direction  Signals                       Item
// s_       in         s_tvalid s_tready s_tdata     insert or remove command
//                     s_tuser
// m_       out        m_tvalid m_tready m_tdata     head, count and status
//                     m_tuser
//
// One item is taken per clock cycle. All cells compare their key with the
// incoming key at once, and in the same cycle each cell keeps its entry,
// takes the new entry or takes its neighbor's entry, so an item never waits
// on another. The result is held in an output register; a new item is
// accepted whenever that register is empty or is being read in that cycle.
// Reset clears the fill count and the output register; entry contents are
// undefined until written and are never shown while unoccupied.
//
module sorted_min_priority_queue #(
	parameter int DEPTH = smpq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // key [31:0], label [47:32]
	input  logic        s_tuser,   // kind [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // head_key [31:0], head_label [47:32],
	                               // head_valid [48], entry_count [55:49]
	output logic [1:0]  m_tuser    // status [1:0]
);

	localparam int COUNT_W = $clog2(DEPTH + 1);

	smpq_pkg::cmd_t                    cmd;
	smpq_pkg::entry_t                  cell_ent  [DEPTH];
	smpq_pkg::entry_t                  left_ent  [DEPTH];
	smpq_pkg::entry_t                  right_ent [DEPTH];
	logic                              cell_ge   [DEPTH];
	logic                              left_ge   [DEPTH];
	logic [COUNT_W-1:0]                count_q;
	logic [smpq_pkg::STATUS_W-1:0]     status_q;
	logic [smpq_pkg::STATUS_W-1:0]     status_nxt;
	logic                              out_valid_q;
	logic                              accept;
	logic                              full;
	logic                              empty;
	logic                              head_valid;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = count_q == COUNT_W'(DEPTH);
	assign empty    = count_q == '0;

	// Commands reach every cell only in the cycle an item is accepted.
	always_comb begin
		cmd.ins       = accept && (s_tuser == smpq_pkg::KIND_INSERT);
		cmd.rem       = accept && (s_tuser == smpq_pkg::KIND_REMOVE);
		cmd.ent.key   = s_tdata[31:0];
		cmd.ent.label = s_tdata[47:32];
	end

	// Neighbor wiring. The first cell has nothing to its left, so it never
	// takes a shifted entry; the last cell takes don't-care data on a remove
	// because it then falls outside the fill count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_ge[i]  = 1'b0;
			assign left_ent[i] = '0;
		end else begin : g_mid_l
			assign left_ge[i]  = cell_ge[i-1];
			assign left_ent[i] = cell_ent[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_ent[i] = '0;
		end else begin : g_mid_r
			assign right_ent[i] = cell_ent[i+1];
		end

		smpq_cell #(
			.INDEX   (i),
			.COUNT_W (COUNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count_q),
			.left_ge   (left_ge[i]),
			.left_ent  (left_ent[i]),
			.right_ent (right_ent[i]),
			.ge        (cell_ge[i]),
			.ent       (cell_ent[i])
		);
	end

	// A full insert keeps the count: the largest entry, possibly the new
	// one, falls off the end of the chain. A remove from an empty queue
	// changes nothing.
	always_comb begin
		status_nxt = smpq_pkg::ST_OK;
		if (cmd.ins && full) begin
			status_nxt = smpq_pkg::ST_FULL;
		end else if (cmd.rem && empty) begin
			status_nxt = smpq_pkg::ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins && !full) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cmd.rem && !empty) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
		end
	end

	// The head is read straight from the first cell: the chain changes only
	// when an item is accepted, which is also when the result is replaced.
	assign head_valid       = !empty;
	assign m_tvalid         = out_valid_q;
	assign m_tdata[31:0]    = head_valid ? cell_ent[0].key : '0;
	assign m_tdata[47:32]   = head_valid ? cell_ent[0].label : '0;
	assign m_tdata[48]      = head_valid;
	assign m_tdata[55:49]   = smpq_pkg::COUNT_OUT_W'(count_q);
	assign m_tuser          = status_q;

endmodule

/* rtl/smpq_checker.sv */
// ---------------------------------------------------------------------------
// smpq_checker: port-level checks of the sorted minimum priority queue
// Watches the stream ports and flags results that cannot be right.
// ---------------------------------------------------------------------------
module smpq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// Every accepted item shows a result in the following cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted item produced no result");

	// A waiting result holds still.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// An empty queue shows a zero head.
	a_empty_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[48] |-> m_tdata[47:0] == 48'd0)
		else $error("empty queue shows a nonzero head");

	// A remove from empty leaves the queue empty with a zero count.
	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == smpq_pkg::ST_EMPTY)
		|-> !m_tdata[48] && (m_tdata[55:49] == 7'd0))
		else $error("remove-from-empty status with a non-empty queue");

	// An overflow can only be reported while entries are held.
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == smpq_pkg::ST_FULL) |-> m_tdata[48])
		else $error("overflow status with an empty queue");

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (.*);

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench: self-checking bench for sorted_min_priority_queue
// Drives insert and remove items through the input stream, keeps its own
// sorted copy of the queue and checks every result item field by field.
// ---------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import smpq_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 8;     // idle wait after the last result is checked
	localparam int WATCHDOG_LIMIT = 2000;  // well above the longest hold-off

	// What one result item should carry.
	typedef struct {
		logic [KEY_W-1:0]       key;
		logic [LABEL_W-1:0]     label;
		logic                   valid;
		logic [COUNT_OUT_W-1:0] count;
		logic [STATUS_W-1:0]    status;
	} head_report_t;

	typedef enum {RUN_FILL, RUN_DRAIN, RUN_MIX} run_mode_e;

	// Keeps a sorted copy of the queue and the results still owed by the block.
	class sorted_queue_scoreboard;
		entry_t       slots [DEPTH_DEF];
		int unsigned  fill;
		head_report_t awaited [$];
		int unsigned  mismatches;
		int unsigned  results_seen;
		int unsigned  inserts;
		int unsigned  removes;
		int unsigned  overflows;
		int unsigned  empty_removes;
		int unsigned  peak_fill;

		function new();
			fill          = 0;
			mismatches    = 0;
			results_seen  = 0;
			inserts       = 0;
			removes       = 0;
			overflows     = 0;
			empty_removes = 0;
			peak_fill     = 0;
		endfunction

		// Apply one accepted item to the copy and queue up the head it leaves.
		function void note_item(logic kind, logic [KEY_W-1:0] key,
				logic [LABEL_W-1:0] label);
			int                  pos;
			int                  last;
			logic [STATUS_W-1:0] status;
			head_report_t        head;

			status = ST_OK;
			if (kind == KIND_INSERT) begin
				inserts++;
				// The new entry goes ahead of the first key not below it,
				// so among equal keys the newest one ends up first.
				pos = 0;
				while (pos < int'(fill) && slots[pos].key < key)
					pos++;
				if (fill >= DEPTH_DEF) begin
					status = ST_FULL;
					overflows++;
					last = DEPTH_DEF - 1;
				end else begin
					last = int'(fill);
					fill++;
				end
				// On a full queue a key above every stored one is itself lost.
				if (pos < DEPTH_DEF) begin
					for (int i = last; i > pos; i--)
						slots[i] = slots[i - 1];
					slots[pos] = {key, label};
				end
			end else begin
				removes++;
				if (fill == 0) begin
					status = ST_EMPTY;
					empty_removes++;
				end else begin
					for (int i = 1; i < int'(fill); i++)
						slots[i - 1] = slots[i];
					fill--;
				end
			end
			if (fill > peak_fill)
				peak_fill = fill;

			head.valid  = (fill != 0);
			head.key    = (fill != 0) ? slots[0].key : '0;
			head.label  = (fill != 0) ? slots[0].label : '0;
			head.count  = COUNT_OUT_W'(fill);
			head.status = status;
			awaited.push_back(head);
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			$display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
				results_seen, what, got, want);
			mismatches++;
		endtask

		// Compare one result item against the oldest expectation.
		task check_head(logic [55:0] data, logic [1:0] user);
			head_report_t want;

			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch("unrequested result", data, 0);
			end else begin
				want = awaited.pop_front();
				if (data[31:0] !== want.key)
					report_mismatch("head_key", data[31:0], want.key);
				if (data[47:32] !== want.label)
					report_mismatch("head_label", data[47:32], want.label);
				if (data[48] !== want.valid)
					report_mismatch("head_valid", data[48], want.valid);
				if (data[55:49] !== want.count)
					report_mismatch("entry_count", data[55:49], want.count);
				if (user !== want.status)
					report_mismatch("status", user, want.status);
			end
		endtask

		function int unsigned outstanding();
			return awaited.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;   // key [31:0], label [47:32]
	logic        s_tuser  = 1'b0; // kind [0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // head_key [31:0], head_label [47:32],
	                              // head_valid [48], entry_count [55:49]
	logic [1:0]  m_tuser;         // status [1:0]

	sorted_queue_scoreboard queue_copy = new();

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned phase         = 0;
	logic        hold_off      = 1'b0;
	int unsigned stall_cycles  = 0;

	// Stimulus-side view of the fill level, used only to steer the random runs.
	run_mode_e   run_mode = RUN_FILL;
	int unsigned level    = 0;

	sorted_min_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both handshakes are sampled with their values from before the edge, since
	// every input changes only through nonblocking assignments at the edge.
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			queue_copy.note_item(s_tuser, s_tdata[31:0], s_tdata[47:32]);
		if (m_tvalid && m_tready)
			queue_copy.check_head(m_tdata, m_tuser);
	end

	// Receiver: random stalls, or a solid hold-off while the pressure window is open.
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// The hold-off is timed here so the sender keeps offering items meanwhile.
	// With the result register full the block has to drop s_tready.
	initial begin
		wait (phase == 3);
		repeat (100) @(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Any cycle with a handshake on either side restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results outstanding",
					stall_cycles, queue_copy.outstanding());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Offer one item, idling first at the sender's current rate, and return
	// at the edge where it is taken.
	task automatic send_item(input logic kind, input logic [KEY_W-1:0] key,
			input logic [LABEL_W-1:0] label);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {label, key};
		s_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Keys favor zero and a few whole-number distances so that ties are common.
	// Without allow_top the key stays below 0xF0000000, which leaves room for
	// an overflow key that is larger than every stored one.
	function automatic logic [KEY_W-1:0] pick_key(input logic allow_top);
		logic [KEY_W-1:0] k;

		case ($urandom_range(7))
			0:       k = '0;
			1:       k = KEY_W'($urandom_range(3)) << 16;
			2:       k = allow_top ? '1 : KEY_W'($urandom_range(15));
			default: k = $urandom();
		endcase
		if (!allow_top)
			k[28] = 1'b0;
		return k;
	endfunction

	// Extremes of both fields, ties, removes from empty, and removes that
	// carry junk in the ignored fields. The queue ends empty.
	task automatic directed_items();
		send_item(KIND_REMOVE, '0, '0);
		send_item(KIND_INSERT, 32'h0001_0000, 16'h1111);
		send_item(KIND_INSERT, 32'h0001_0000, 16'h2222);
		send_item(KIND_INSERT, 32'h0000_0000, 16'hFFFF);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'h0000);
		send_item(KIND_INSERT, 32'h0000_8000, 16'hAAAA);
		send_item(KIND_INSERT, 32'hFFFF_FFFF, 16'h5555);
		send_item(KIND_INSERT, 32'h7FFF_FFFF, 16'h8000);
		send_item(KIND_REMOVE, '1, '1);
		repeat (6)
			send_item(KIND_REMOVE, '0, '0);
		send_item(KIND_REMOVE, '1, '1);
	endtask

	// Random items in runs that fill the queue past full, drain it past empty,
	// or mix both, so the block spends time at every fill level.
	task automatic random_run(input int unsigned n);
		logic             kind;
		logic [KEY_W-1:0] key;
		int unsigned      insert_pct;

		for (int unsigned k = 0; k < n; k++) begin
			case (run_mode)
				RUN_FILL:  insert_pct = 85;
				RUN_DRAIN: insert_pct = 15;
				default:   insert_pct = 50;
			endcase
			kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
			key  = $urandom();
			if (kind == KIND_INSERT) begin
				if (level == DEPTH && $urandom_range(4) < 2)
					key = 32'hF000_0000 | $urandom();
				else
					key = pick_key(run_mode != RUN_FILL);
			end
			send_item(kind, key, LABEL_W'($urandom()));

			if (kind == KIND_INSERT) begin
				if (level < DEPTH)
					level++;
			end else if (level > 0) begin
				level--;
			end

			case (run_mode)
				RUN_FILL: begin
					if (level == DEPTH && $urandom_range(5) == 0)
						run_mode = RUN_DRAIN;
				end
				RUN_DRAIN: begin
					if (level == 0 && $urandom_range(2) == 0) begin
						if ($urandom_range(1) == 0)
							run_mode = RUN_FILL;
						else
							run_mode = RUN_MIX;
					end
				end
				default: begin
					if ($urandom_range(39) == 0)
						run_mode = RUN_FILL;
				end
			endcase
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase         = 1;
		send_idle_pct = 37;
		recv_idle_pct = 51;
		directed_items();
		random_run(480);

		phase         = 2;
		send_idle_pct = 51;
		recv_idle_pct = 37;
		random_run(485);

		// No idling here, apart from the long receiver hold-off.
		phase         = 3;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_run(485);
		s_tvalid <= 1'b0;

		while (queue_copy.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d inserts and %0d removes, %0d results checked",
			queue_copy.inserts, queue_copy.removes, queue_copy.results_seen);
		$display("full-queue inserts %0d, removes from empty %0d, peak fill %0d, mismatches %0d",
			queue_copy.overflows, queue_copy.empty_removes, queue_copy.peak_fill,
			queue_copy.mismatches);
		if (queue_copy.mismatches == 0 && queue_copy.outstanding() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/sorted_min_priority_queue.sv
rtl/smpq_checker.sv
tb/sv/testbench.sv
